// ----- hdl/fixed_block_pool_allocator_top_defines.svh -----
// assertion macros for the block pool allocator checker
// no dependencies
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FBPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbpa assertion failed");

// next-cycle implication
`define FBPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbpa assertion failed");

`endif

// ----- hdl/fbpa_pkg.sv -----
// shared types and constants of the block pool allocator
// no dependencies
package fbpa_pkg;

  localparam int ADDR_W     = 32;
  localparam int RBYTES_W   = 24;
  localparam int PBYTES_W   = 16;
  localparam int STRIDE_W   = 17;
  localparam int LEN_W      = 32;
  localparam int ALIGN_W    = 8;
  localparam int OPC_W      = 2;
  localparam int FREE_W     = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_MAX_BLOCKS   = 4096;
  localparam int DEF_HEADER_BYTES = 8;
  localparam int DEF_MIN_PAYLOAD  = 8;

  localparam logic [ALIGN_W-1:0] ALIGN_ONE = 8'd1;

  localparam logic [OPC_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OPC_W-1:0] OP_ACQUIRE = 2'd1;
  localparam logic [OPC_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_BYTES = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ALIGN   = 3'd1,
    ST_ZERO    = 3'd2,
    ST_OOM     = 3'd3,
    ST_FOREIGN = 3'd4,
    ST_DOUBLE  = 3'd5,
    ST_SIZE    = 3'd6
  } status_t;

endpackage

// ----- hdl/fixed_block_pool_allocator_top.sv -----
// Fixed-size block pool allocator with a LIFO free list. Links and used marks
// live in two synchronous rams; a shared 32-step serial divider serves init
// (block count) and release (block index and stride check). Init divides the
// region by the stride and then fills the free list, writing one link per
// cycle; acquire reads the head link and marks the block used; release checks
// the header distance, divides it and reads the used mark. Requests that fail
// their first check, null releases, init without a region and unknown opcodes
// go straight to the result. A stalled result holds the block in its result
// state. No clearing pass is needed after reset. One request is in flight at
// a time; a finished result waits in an output register.
// depends on fbpa_pkg, fbpa_ram, fbpa_div
module fixed_block_pool_allocator_top #(
  parameter int MAX_BLOCKS   = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = fbpa_pkg::DEF_HEADER_BYTES,
  parameter int MIN_PAYLOAD  = fbpa_pkg::DEF_MIN_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fbpa_pkg::OPC_W-1:0]      in_opcode,
  input  logic [fbpa_pkg::LEN_W-1:0]      in_request_length,
  input  logic [fbpa_pkg::ALIGN_W-1:0]    in_request_align,
  input  logic [fbpa_pkg::ADDR_W-1:0]     in_block_address,
  input  logic                            in_address_is_null,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fbpa_pkg::status_t               out_status,
  output logic [fbpa_pkg::ADDR_W-1:0]     out_granted_address,
  output logic [fbpa_pkg::FREE_W-1:0]     out_free_blocks
);

  import fbpa_pkg::*;

  localparam int IW     = $clog2(MAX_BLOCKS);
  localparam int CW     = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = IW + STRIDE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_DIV,
    S_INIT_FILL,
    S_ACQ_RD,
    S_ACQ_UPD,
    S_REL_CHK,
    S_REL_DIV,
    S_REL_RD,
    S_REL_UPD,
    S_OUT
  } state_t;

  state_t                state_r;
  logic [ADDR_W-1:0]     region_base_r;
  logic [RBYTES_W-1:0]   region_bytes_r;
  logic [PBYTES_W-1:0]   payload_bytes_r;
  logic [IW-1:0]         free_head_r;
  logic [CW-1:0]         free_total_r;
  logic [CW-1:0]         block_total_r;
  logic [STRIDE_W-1:0]   stride_r;
  logic [PBYTES_W-1:0]   lim_r;
  logic [CW-1:0]         fill_r;
  logic [ADDR_W-1:0]     diff_r;
  logic [IW-1:0]         idx_r;
  logic [PROD_W-1:0]     prod_r;
  status_t               res_status_r;
  logic [ADDR_W-1:0]     res_addr_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [FREE_W-1:0]     out_free_r;

  logic                  acc;
  logic [STRIDE_W-1:0]   new_stride;
  logic                  acq_too_long;
  logic                  rel_short;
  logic [ADDR_W-1:0]     rel_dist;
  logic [PROD_W-1:0]     prod_nxt;
  logic [ADDR_W-1:0]     granted_nxt;
  logic [CW-1:0]         fill_prev;
  logic [CW-1:0]         total_prev;
  logic [CW-1:0]         count_sat;

  logic                  div_start;
  logic [ADDR_W-1:0]     div_dividend;
  logic [STRIDE_W-1:0]   div_divisor;
  logic                  div_done;
  logic [ADDR_W-1:0]     div_quo;
  logic [STRIDE_W-1:0]   div_rem;

  logic                  nf_we;
  logic [IW-1:0]         nf_waddr;
  logic [IW-1:0]         nf_wdata;
  logic [IW-1:0]         nf_rdata;
  logic                  um_we;
  logic [IW-1:0]         um_waddr;
  logic [0:0]            um_wdata;
  logic [0:0]            um_rdata;

  assign acc = in_valid && in_ready;

  always_comb begin
    new_stride   = STRIDE_W'(payload_bytes_r) + STRIDE_W'(HEADER_BYTES);
    acq_too_long = in_request_length > LEN_W'(lim_r);
    rel_short    = diff_r < ADDR_W'(HEADER_BYTES);
    rel_dist     = diff_r - ADDR_W'(HEADER_BYTES);
    prod_nxt     = PROD_W'(free_head_r) * PROD_W'(stride_r);
    granted_nxt  = region_base_r + ADDR_W'(prod_r) + ADDR_W'(HEADER_BYTES);
    fill_prev    = fill_r - CW'(1);
    total_prev   = block_total_r - CW'(1);
    count_sat    = (div_quo > ADDR_W'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : div_quo[CW-1:0];
  end

  // divider operand select
  always_comb begin
    div_start    = 1'b0;
    div_dividend = ADDR_W'(region_bytes_r);
    div_divisor  = new_stride;
    if (state_r == S_REL_CHK) begin
      div_start    = !rel_short;
      div_dividend = rel_dist;
      div_divisor  = stride_r;
    end else if (acc && (in_opcode == OP_INIT)) begin
      div_start = (payload_bytes_r >= PBYTES_W'(MIN_PAYLOAD)) && (region_base_r != '0);
    end
  end

  // ram write ports
  always_comb begin
    nf_we    = 1'b0;
    nf_waddr = idx_r;
    nf_wdata = free_head_r;
    um_we    = 1'b0;
    um_waddr = idx_r;
    um_wdata = 1'b0;
    case (state_r)
      S_INIT_FILL: begin
        if (fill_r != block_total_r) begin
          nf_we    = 1'b1;
          nf_waddr = fill_r[IW-1:0];
          nf_wdata = (fill_r == '0) ? '0 : fill_prev[IW-1:0];
          um_we    = 1'b1;
          um_waddr = fill_r[IW-1:0];
        end
      end
      S_ACQ_UPD: begin
        um_we    = 1'b1;
        um_waddr = free_head_r;
        um_wdata = 1'b1;
      end
      S_REL_UPD: begin
        if (um_rdata[0]) begin
          nf_we = 1'b1;
          um_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      region_base_r   <= '0;
      region_bytes_r  <= '0;
      payload_bytes_r <= PBYTES_W'(MIN_PAYLOAD);
      free_head_r     <= '0;
      free_total_r    <= '0;
      block_total_r   <= '0;
      stride_r        <= STRIDE_W'(MIN_PAYLOAD + HEADER_BYTES);
      lim_r           <= PBYTES_W'(MIN_PAYLOAD);
      fill_r          <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REGION_BASE:   region_base_r   <= cfg_data[ADDR_W-1:0];
          CFG_REGION_BYTES:  region_bytes_r  <= cfg_data[RBYTES_W-1:0];
          CFG_PAYLOAD_BYTES: payload_bytes_r <= cfg_data[PBYTES_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (acc) begin
            res_addr_r   <= '0;
            res_status_r <= ST_OK;
            case (in_opcode)
              OP_INIT: begin
                if (payload_bytes_r < PBYTES_W'(MIN_PAYLOAD)) begin
                  res_status_r <= ST_SIZE;
                  state_r      <= S_OUT;
                end else begin
                  stride_r      <= new_stride;
                  lim_r         <= payload_bytes_r;
                  free_head_r   <= '0;
                  free_total_r  <= '0;
                  block_total_r <= '0;
                  state_r       <= (region_base_r == '0) ? S_OUT : S_INIT_DIV;
                end
              end
              OP_ACQUIRE: begin
                if (in_request_align != ALIGN_ONE) begin
                  res_status_r <= ST_ALIGN;
                  state_r      <= S_OUT;
                end else if (in_request_length == '0) begin
                  res_status_r <= ST_ZERO;
                  state_r      <= S_OUT;
                end else if (acq_too_long || (free_total_r == '0)) begin
                  res_status_r <= ST_OOM;
                  state_r      <= S_OUT;
                end else begin
                  state_r <= S_ACQ_RD;
                end
              end
              OP_RELEASE: begin
                diff_r  <= in_block_address - region_base_r;
                state_r <= in_address_is_null ? S_OUT : S_REL_CHK;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_INIT_DIV: begin
          if (div_done) begin
            block_total_r <= count_sat;
            fill_r        <= '0;
            state_r       <= S_INIT_FILL;
          end
        end
        S_INIT_FILL: begin
          if (fill_r == block_total_r) begin
            free_total_r <= block_total_r;
            free_head_r  <= (block_total_r == '0) ? '0 : total_prev[IW-1:0];
            state_r      <= S_OUT;
          end else begin
            fill_r <= fill_r + CW'(1);
          end
        end
        S_ACQ_RD: begin
          prod_r  <= prod_nxt;
          state_r <= S_ACQ_UPD;
        end
        S_ACQ_UPD: begin
          free_head_r  <= nf_rdata;
          free_total_r <= free_total_r - CW'(1);
          res_addr_r   <= granted_nxt;
          state_r      <= S_OUT;
        end
        S_REL_CHK: begin
          if (rel_short) begin
            res_status_r <= ST_FOREIGN;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_REL_DIV;
          end
        end
        S_REL_DIV: begin
          if (div_done) begin
            if ((div_rem != '0) || (div_quo >= ADDR_W'(block_total_r))) begin
              res_status_r <= ST_FOREIGN;
              state_r      <= S_OUT;
            end else begin
              idx_r   <= div_quo[IW-1:0];
              state_r <= S_REL_RD;
            end
          end
        end
        S_REL_RD: begin
          state_r <= S_REL_UPD;
        end
        S_REL_UPD: begin
          if (!um_rdata[0]) begin
            res_status_r <= ST_DOUBLE;
          end else begin
            free_head_r  <= idx_r;
            free_total_r <= free_total_r + CW'(1);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_free_r   <= FREE_W'(free_total_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  fbpa_div #(
    .DVD_W(ADDR_W),
    .DVS_W(STRIDE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  fbpa_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_BLOCKS)
  ) u_next_free (
    .clk  (clk),
    .we   (nf_we),
    .waddr(nf_waddr),
    .wdata(nf_wdata),
    .raddr(free_head_r),
    .rdata(nf_rdata)
  );

  fbpa_ram #(
    .WIDTH(1),
    .DEPTH(MAX_BLOCKS)
  ) u_used_mark (
    .clk  (clk),
    .we   (um_we),
    .waddr(um_waddr),
    .wdata(um_wdata),
    .raddr(idx_r),
    .rdata(um_rdata)
  );

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_free_blocks     = out_free_r;

endmodule

// ----- hdl/fbpa_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/fbpa_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
// no dependencies
module fbpa_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] div_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    fits    = (rem_sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DVD_W-2:0], fits};
        rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- hdl/fbpa_checker.sv -----
// port-level checks of the block pool allocator, bound to the top level
// depends on fbpa_pkg and fixed_block_pool_allocator_top_defines.svh
`include "fixed_block_pool_allocator_top_defines.svh"

module fbpa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input fbpa_pkg::status_t           out_status,
  input logic [fbpa_pkg::ADDR_W-1:0] out_granted_address,
  input logic [fbpa_pkg::FREE_W-1:0] out_free_blocks
);

  import fbpa_pkg::*;

  // stalled result holds
  `FBPA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_granted_address) && $stable(out_free_blocks))

  // one request in flight
  `FBPA_ASSERT_NXT(a_one_request, clk, rst_n, in_valid && in_ready, !in_ready)

  // no result rises right after a request is accepted
  `FBPA_ASSERT_NXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

  // an address goes out only with a good status
  `FBPA_ASSERT_IMP(a_addr_only_ok, clk, rst_n, out_valid && (out_status != ST_OK), out_granted_address == '0)

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
